/* rtl/fadc_readout_stream_parser_defines.svh */
// Assertion macros for the readout stream parser.
// Used by the top level only; no other dependencies.
`ifndef FADC_READOUT_STREAM_PARSER_DEFINES_SVH
`define FADC_READOUT_STREAM_PARSER_DEFINES_SVH
// Clocked implication check with asynchronous reset disable.
`define FRP_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication check.
`define FRP_ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/frp_pkg.sv */
// Shared types and constants of the readout stream parser.
// No dependencies.
package frp_pkg;
    localparam logic [3:0] PH_WAIT    = 4'd0;
    localparam logic [3:0] PH_EVENT   = 4'd1;
    localparam logic [3:0] PH_BLKSKIP = 4'd2;
    localparam logic [3:0] PH_MODULE  = 4'd3;
    localparam logic [3:0] PH_TRAILER = 4'd4;
    localparam logic [3:0] PH_DHDR0   = 4'd5;
    localparam logic [3:0] PH_DHDR1   = 4'd6;
    localparam logic [3:0] PH_DSKIP   = 4'd7;
    localparam logic [3:0] PH_DDATA   = 4'd8;
    localparam logic [3:0] PH_DIV     = 4'd9;

    localparam logic [2:0] REG_EVENT_MARKER = 3'd0;
    localparam logic [2:0] REG_BLOCK_MARKER = 3'd1;
    localparam logic [2:0] REG_HEADER_WORDS = 3'd2;
    localparam logic [2:0] REG_MODULE_ID    = 3'd3;
    localparam logic [2:0] REG_FIRST_INDEX  = 3'd4;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_RECORD = 2'd2;

    // Command from the parser to the emitter.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  channel;
        logic [23:0] samples;
        logic [31:0] event_num;
        logic        corrupt;
    } frp_cmd_t;
endpackage

/* rtl/frp_queue.sv */
// Two-entry queue carrying commands from the parser to the emitter.
// Depends on frp_pkg.
module frp_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  frp_pkg::frp_cmd_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output frp_pkg::frp_cmd_t head
);
    import frp_pkg::*;

    frp_cmd_t   mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* rtl/frp_emitter.sv */
// Back end: turns queued commands into one or two result requests.
// Depends on frp_pkg.
module frp_emitter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  frp_pkg::frp_cmd_t q_head,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);
    import frp_pkg::*;

    logic half_reg, half_next;
    logic take;
    logic is_record;
    logic [11:0] raw;
    logic [11:0] smp;

    assign m_tvalid  = q_not_empty;
    assign take      = m_tvalid && m_tready;
    assign is_record = (q_head.cmd == CMD_RECORD);
    assign raw       = half_reg ? q_head.samples[23:12] : q_head.samples[11:0];
    // Offset binary to two's complement: flip the sign bit.
    assign smp       = is_record ? 12'd0 : (raw ^ 12'h800);
    assign m_tlast   = is_record || half_reg;
    // tdata: channel_number[2:0], sample_value[11:0], event_number[31:0], event_corrupt
    assign m_tdata   = {is_record && q_head.corrupt, q_head.event_num, smp,
                        is_record ? 3'd0 : q_head.channel};
    // tuser: result_kind
    assign m_tuser   = is_record;

    assign q_pop = take && m_tlast;

    always_comb
    begin
        half_next = half_reg;
        if (take)
        begin
            half_next = !m_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
        end
        else
        begin
            half_reg <= half_next;
        end
    end
endmodule

/* rtl/frp_parser.sv */
// Front end: runs the word-level state machine and queues output commands.
// Depends on frp_pkg.
module frp_parser #(
    parameter int CHANNEL_COUNT = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              s_tuser,
    input  logic [31:0]       event_marker,
    input  logic [31:0]       block_marker,
    input  logic [6:0]        header_words,
    input  logic [3:0]        dig_id,
    input  logic              index_load,
    input  logic [31:0]       index_value,
    input  logic              q_full,
    output logic              q_push,
    output frp_pkg::frp_cmd_t q_data,
    output logic              busy
);
    import frp_pkg::*;

    localparam logic [7:0] CH_MASK = 8'((1 << CHANNEL_COUNT) - 1);

    logic [3:0]  phase_reg, phase_next;
    logic        corrupt_reg, corrupt_next;
    logic [31:0] evcnt_reg, evcnt_next;
    logic [5:0]  skip_reg, skip_next;
    logic [15:0] mods_reg, mods_next;
    logic [15:0] trail_reg, trail_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  chan_reg, chan_next;
    logic [27:0] wpc_reg, wpc_next;
    logic [27:0] left_reg, left_next;
    // Serial divider state: quotient in wpc, remainder, divisor, bit count.
    logic [3:0]  dvs_reg, dvs_next;
    logic [3:0]  rem_reg, rem_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic [3:0]  from_reg, from_next;

    logic        take;
    logic [31:0] w;
    logic [7:0]  word_mask;
    logic [3:0]  pc;
    logic [4:0]  trial;
    logic [3:0]  sel;
    logic        found;
    logic [6:0]  skip_w;

    assign s_tready = (phase_reg != PH_DIV) && (from_reg[3] || 1'b1) && !q_full
                      && (phase_reg != PH_DSKIP || skip_reg != 6'd0);
    assign take     = s_tvalid && s_tready;
    assign w        = s_tdata;
    assign busy     = (phase_reg == PH_DIV);

    // First enabled channel at or above from_reg.
    always_comb
    begin
        found = 1'b0;
        sel   = 4'd0;
        for (int i = CHANNEL_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i] && (4'(i) >= from_reg))
            begin
                found = 1'b1;
                sel   = 4'(i);
            end
        end
    end

    // Channel mask of the incoming word and its population count.
    assign word_mask = w[7:0] & CH_MASK;

    always_comb
    begin
        pc = '0;
        for (int i = 0; i < 8; i++)
        begin
            pc = pc + {3'd0, word_mask[i]};
        end
    end

    assign trial  = {rem_reg, wpc_reg[27]};
    assign skip_w = (header_words == 7'd0) ? 7'd0 :
                    ((header_words - 7'd1) > 7'd63 ? 7'd63 : header_words - 7'd1);

    always_comb
    begin
        phase_next   = phase_reg;
        corrupt_next = corrupt_reg;
        evcnt_next   = evcnt_reg;
        skip_next    = skip_reg;
        mods_next    = mods_reg;
        trail_next   = trail_reg;
        mask_next    = mask_reg;
        chan_next    = chan_reg;
        wpc_next     = wpc_reg;
        left_next    = left_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        from_next    = from_reg;
        q_push       = 1'b0;
        q_data       = '0;
        q_data.event_num = evcnt_reg;
        q_data.corrupt   = corrupt_reg;
        q_data.channel   = chan_reg;
        q_data.samples   = {w[27:16], w[11:0]};

        // Channel selection pending after skip or channel end.
        if (phase_reg == PH_DSKIP && skip_reg == 6'd0)
        begin
            if (wpc_reg != 28'd0 && found)
            begin
                chan_next  = sel[2:0];
                left_next  = wpc_reg;
                phase_next = PH_DDATA;
            end
            else
            begin
                if (mods_reg != 16'hffff)
                begin
                    mods_next = mods_reg + 16'd1;
                end
                phase_next = PH_MODULE;
            end
        end
        else if (phase_reg == PH_DIV)
        begin
            // Restoring division, one quotient bit per cycle.
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 4'(trial - {1'b0, dvs_reg});
                wpc_next = {wpc_reg[26:0], 1'b1};
            end
            else
            begin
                rem_next = trial[3:0];
                wpc_next = {wpc_reg[26:0], 1'b0};
            end
            dcnt_next = dcnt_reg - 5'd1;
            if (dcnt_reg == 5'd1)
            begin
                phase_next = PH_DSKIP;
            end
        end
        else if (take && s_tuser)
        begin
            q_push     = 1'b1;
            q_data.cmd = CMD_RECORD;
            evcnt_next = evcnt_reg + 32'd1;
            corrupt_next = 1'b0;
            phase_next = PH_WAIT;
        end
        else if (take)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (w == event_marker)
                    begin
                        phase_next = PH_EVENT;
                    end
                end
                PH_EVENT:
                begin
                    if (w == event_marker)
                    begin
                        q_push       = 1'b1;
                        q_data.cmd   = CMD_RECORD;
                        evcnt_next   = evcnt_reg + 32'd1;
                        corrupt_next = 1'b0;
                    end
                    else if (w == block_marker)
                    begin
                        skip_next  = skip_w[5:0];
                        mods_next  = '0;
                        phase_next = (skip_w != 7'd0) ? PH_BLKSKIP : PH_MODULE;
                    end
                end
                PH_BLKSKIP:
                begin
                    skip_next = skip_reg - 6'd1;
                    if (skip_reg == 6'd1)
                    begin
                        phase_next = PH_MODULE;
                    end
                end
                PH_MODULE:
                begin
                    if (w[23:16] == 8'h82)
                    begin
                        if (w[3:0] == dig_id)
                        begin
                            phase_next = PH_DHDR0;
                        end
                    end
                    else
                    begin
                        if (w != 32'd0)
                        begin
                            corrupt_next = 1'b1;
                        end
                        if (mods_reg != 16'd0)
                        begin
                            trail_next = mods_reg - 16'd1;
                            phase_next = PH_TRAILER;
                        end
                        else
                        begin
                            phase_next = PH_EVENT;
                        end
                    end
                end
                PH_TRAILER:
                begin
                    if (trail_reg != 16'd0)
                    begin
                        if (w != 32'd0)
                        begin
                            corrupt_next = 1'b1;
                        end
                        trail_next = trail_reg - 16'd1;
                    end
                    else
                    begin
                        if (w != {16'd0, mods_reg})
                        begin
                            corrupt_next = 1'b1;
                        end
                        phase_next = PH_EVENT;
                    end
                end
                PH_DHDR0:
                begin
                    if (w[31:28] != 4'ha)
                    begin
                        corrupt_next = 1'b1;
                        phase_next   = PH_EVENT;
                    end
                    else
                    begin
                        wpc_next   = (w[27:0] < 28'd4) ? 28'd0 : w[27:0] - 28'd4;
                        phase_next = PH_DHDR1;
                    end
                end
                PH_DHDR1:
                begin
                    mask_next  = word_mask;
                    skip_next  = 6'd2;
                    from_next  = 4'd0;
                    rem_next   = 4'd0;
                    dvs_next   = pc;
                    dcnt_next  = 5'd28;
                    if (pc == 4'd0)
                    begin
                        wpc_next   = '0;
                        phase_next = PH_DSKIP;
                    end
                    else
                    begin
                        phase_next = PH_DIV;
                    end
                end
                PH_DSKIP:
                begin
                    skip_next = skip_reg - 6'd1;
                end
                PH_DDATA:
                begin
                    q_push     = 1'b1;
                    q_data.cmd = CMD_SAMPLE;
                    left_next  = left_reg - 28'd1;
                    if (left_reg == 28'd1)
                    begin
                        from_next  = {1'b0, chan_reg} + 4'd1;
                        skip_next  = 6'd0;
                        phase_next = PH_DSKIP;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end

        if (index_load)
        begin
            evcnt_next = index_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            corrupt_reg <= 1'b0;
            evcnt_reg   <= '0;
            skip_reg    <= '0;
            mods_reg    <= '0;
            trail_reg   <= '0;
            mask_reg    <= '0;
            chan_reg    <= '0;
            wpc_reg     <= '0;
            left_reg    <= '0;
            dvs_reg     <= '0;
            rem_reg     <= '0;
            dcnt_reg    <= '0;
            from_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            corrupt_reg <= corrupt_next;
            evcnt_reg   <= evcnt_next;
            skip_reg    <= skip_next;
            mods_reg    <= mods_next;
            trail_reg   <= trail_next;
            mask_reg    <= mask_next;
            chan_reg    <= chan_next;
            wpc_reg     <= wpc_next;
            left_reg    <= left_next;
            dvs_reg     <= dvs_next;
            rem_reg     <= rem_next;
            dcnt_reg    <= dcnt_next;
            from_reg    <= from_next;
        end
    end
endmodule

/* rtl/fadc_readout_stream_parser.sv */
// A result request is registered in the command queue when its word is accepted.
// Throughput: one word per cycle while the command queue has room; a sample word
// yields two output transfers. A digitizer header mask word with enabled channels
// stalls for the serial divider, and a finished channel for the next-channel search.
// Reset (rst_n, asynchronous) clears all control state; the configuration
// registers take their reset values, with a block header length of 9.
module fadc_readout_stream_parser #(
    parameter int CHANNEL_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // data_word[31:0]
    input  logic        s_tuser,  // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // channel[2:0], sample[11:0], event[31:0], corrupt
    output logic        m_tuser,  // result_kind
    output logic        m_tlast,  // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import frp_pkg::*;
    `include "fadc_readout_stream_parser_defines.svh"

    logic [31:0] ev_marker_reg, blk_marker_reg, first_idx_reg;
    logic [6:0]  hdr_words_reg;
    logic [3:0]  mod_id_reg;
    logic        wr;
    logic [2:0]  ridx;
    logic        q_full, q_push, q_pop, q_ne, busy;
    frp_cmd_t    q_in, q_head;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[4:2];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_marker_reg  <= '0;
            blk_marker_reg <= '0;
            hdr_words_reg  <= 7'd9;
            mod_id_reg     <= '0;
            first_idx_reg  <= '0;
        end
        else if (wr)
        begin
            unique case (ridx)
                REG_EVENT_MARKER: ev_marker_reg  <= pwdata;
                REG_BLOCK_MARKER: blk_marker_reg <= pwdata;
                REG_HEADER_WORDS: hdr_words_reg  <= pwdata[6:0];
                REG_MODULE_ID:    mod_id_reg     <= pwdata[3:0];
                REG_FIRST_INDEX:  first_idx_reg  <= pwdata;
                default:          ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (ridx)
            REG_EVENT_MARKER: prdata = ev_marker_reg;
            REG_BLOCK_MARKER: prdata = blk_marker_reg;
            REG_HEADER_WORDS: prdata = {25'd0, hdr_words_reg};
            REG_MODULE_ID:    prdata = {28'd0, mod_id_reg};
            REG_FIRST_INDEX:  prdata = first_idx_reg;
            default:          prdata = '0;
        endcase
    end

    frp_parser #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_parser (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .event_marker(ev_marker_reg), .block_marker(blk_marker_reg),
        .header_words(hdr_words_reg), .dig_id(mod_id_reg),
        .index_load(wr && ridx == REG_FIRST_INDEX), .index_value(pwdata),
        .q_full(q_full), .q_push(q_push), .q_data(q_in), .busy(busy)
    );

    frp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    frp_emitter u_emit (
        .clk(clk), .rst_n(rst_n), .q_not_empty(q_ne), .q_head(q_head), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    `FRP_ASSERT_IMP(a_no_push_full, q_full && !q_pop, !q_push)
    `FRP_ASSERT_IMP(a_no_take_busy, busy, !s_tready)
    `FRP_ASSERT_NXT(a_pop_drains, q_pop && !q_push && !q_full, !q_full)
endmodule
